/* design/lbp_pkg.sv */
// Shared types, codes and tables for the LBP16 command stream parser.
// No dependencies; the parser top level, lbp_parse_core and lbp_res_fifo import this package.
`default_nettype none

package lbp_pkg;

    // Fixed geometry of the protocol
    localparam int SPACES        = 8;
    localparam int CONTROL_WORDS = 8;

    // Command word bit positions
    localparam int CMD_WRITE_BIT = 15;
    localparam int CMD_ADDR_BIT  = 14;
    localparam int CMD_CTRL_BIT  = 13;
    localparam int CMD_INC_BIT   = 7;

    // Space limits in words
    localparam logic [14:0] SPACE0_LIMIT_RESET = 15'(32'h10000 / 4);
    localparam logic [15:0] SPACE2_LIMIT       = 16'(32'h40 / 2);
    localparam logic [15:0] SPACE3_LIMIT       = 16'd4;
    localparam logic [15:0] SMALL_SPACE_LIMIT  = 16'd16;

    localparam logic [2:0] SPACE_WRITE_ONLY_ERR = 3'd7;

    // Packet status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARSE = 2'd1;
    localparam logic [1:0] ST_MEM   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CTRL  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Sticky error bits
    localparam logic [2:0] ERR_PARSE = 3'b001;
    localparam logic [2:0] ERR_MEM   = 3'b010;
    localparam logic [2:0] ERR_WRITE = 3'b100;

    localparam logic [15:0] COUNT_MAX = 16'hffff;

    // Byte position within a packet
    typedef enum logic [5:0] {
        PH_CMD_LO  = 6'b000001,
        PH_CMD_HI  = 6'b000010,
        PH_ADDR_LO = 6'b000100,
        PH_ADDR_HI = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_DROP    = 6'b100000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  space;
        logic [15:0] word_address;
        logic [1:0]  size_code;
        logic [6:0]  burst_count;
        logic        increment;
        logic [31:0] write_data;
        logic [1:0]  status;
        logic [2:0]  error_bits;
        logic [15:0] parse_errors;
        logic [15:0] memory_errors;
        logic [15:0] write_errors;
    } result_t;

    // Results produced by one byte, in order
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } res_push_t;

    // Element size each space demands (spaces 1 and 5 are never valid)
    function automatic logic [1:0] size_for_space(input logic [2:0] sp);
        logic [1:0] sz;
        unique case (sp) inside
            3'd0, 3'd3: sz = 2'd2;
            3'd2, 3'd4, 3'd6, 3'd7: sz = 2'd1;
            default: sz = 2'd0;
        endcase
        return sz;
    endfunction

    // Word limit per space; space 0 takes the programmed limit
    function automatic logic [15:0] space_limit(input logic [2:0] sp,
                                                input logic [14:0] zero_limit);
        logic [15:0] lim;
        unique case (sp) inside
            3'd0: lim = {1'b0, zero_limit};
            3'd2: lim = SPACE2_LIMIT;
            3'd3: lim = SPACE3_LIMIT;
            3'd4, 3'd6, 3'd7: lim = SMALL_SPACE_LIMIT;
            default: lim = 16'd0;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

/* design/lbp_byte_if.sv */
// Packet byte channel: valid/ready with byte and last-byte flag.
// Depends on nothing.
`default_nettype none

interface lbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

/* design/lbp_res_if.sv */
// Result channel: valid/ready with the decoded access or packet status.
// Depends on nothing.
`default_nettype none

interface lbp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  space;
    logic [15:0] word_address;
    logic [1:0]  size_code;
    logic [6:0]  burst_count;
    logic        increment;
    logic [31:0] write_data;
    logic [1:0]  status;
    logic [2:0]  error_bits;
    logic [15:0] parse_errors;
    logic [15:0] memory_errors;
    logic [15:0] write_errors;

    modport source (output valid, output kind, output space, output word_address,
                    output size_code, output burst_count, output increment,
                    output write_data, output status, output error_bits,
                    output parse_errors, output memory_errors, output write_errors,
                    input ready);
    modport sink   (input valid, input kind, input space, input word_address,
                    input size_code, input burst_count, input increment,
                    input write_data, input status, input error_bits,
                    input parse_errors, input memory_errors, input write_errors,
                    output ready);
endinterface

`default_nettype wire

/* design/lbp_cfg_if.sv */
// Configuration write channel for the space 0 word limit.
// Depends on nothing.
`default_nettype none

interface lbp_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/lbp16_command_stream_parser_unit.sv */
// LBP16 command stream parser, top level.
// Uses lbp_pkg, the three channel interfaces, lbp_parse_core, lbp_res_fifo.
//
// Takes one packet byte per cycle and decodes LBP16 commands on the fly:
// every byte is fully handled in the cycle it is accepted, so the sustained
// rate is one byte per clock while the result port keeps up. Results
// (write accesses, read and control-read burst requests, and one status
// per packet) go into a RES_DEPTH-entry queue in front of the result port;
// the byte port is ready while the queue has room for two results, since
// the last byte of a packet can complete an access and end the packet at
// once. That byte makes two results; the result port gives one per clock,
// and when it stalls, the byte port stops once RES_DEPTH-1 results wait.
// Per-space next addresses and error counters come out of reset cleared.
// The space 0 word limit is written through the configuration channel,
// which is always ready; write it only while no packet is in progress.
`default_nettype none

module lbp16_command_stream_parser_unit #(
    parameter int RES_DEPTH = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lbp_cfg_if.sink    limit_cfg,
    lbp_byte_if.sink   pkt_bytes,
    lbp_res_if.source  results
);
    import lbp_pkg::*;

    res_push_t push;
    result_t   head;
    logic      room_for_two;
    logic      byte_take;

    // Byte handshake
    assign pkt_bytes.ready = room_for_two;
    assign byte_take       = pkt_bytes.valid && room_for_two;
    assign limit_cfg.ready = 1'b1;

    lbp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (limit_cfg.valid),
        .cfg_data  (limit_cfg.data),
        .byte_take (byte_take),
        .byte_data (pkt_bytes.byte_in),
        .byte_last (pkt_bytes.last_byte),
        .push      (push)
    );

    lbp_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (results.valid),
        .out_take     (results.valid && results.ready),
        .out_data     (head)
    );

    // Result fields
    assign results.kind          = head.kind;
    assign results.space         = head.space;
    assign results.word_address  = head.word_address;
    assign results.size_code     = head.size_code;
    assign results.burst_count   = head.burst_count;
    assign results.increment     = head.increment;
    assign results.write_data    = head.write_data;
    assign results.status        = head.status;
    assign results.error_bits    = head.error_bits;
    assign results.parse_errors  = head.parse_errors;
    assign results.memory_errors = head.memory_errors;
    assign results.write_errors  = head.write_errors;

endmodule

`default_nettype wire

/* design/lbp_parse_core.sv */
// Byte-serial command decoder: packet state, per-space next addresses,
// error counters and result generation. Uses lbp_pkg.
`default_nettype none

module lbp_parse_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [14:0]       cfg_data,
    input  wire logic              byte_take,
    input  wire logic [7:0]        byte_data,
    input  wire logic              byte_last,
    output lbp_pkg::res_push_t     push
);
    import lbp_pkg::*;

    // State registers
    phase_t      phase_reg, phase_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [6:0]  elem_left_reg, elem_left_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  idx_reg, idx_next;
    logic [15:0] next_addr_reg [SPACES];
    logic [1:0]  pf_reg, pf_next;
    logic [2:0]  sticky_reg, sticky_next;
    logic [15:0] parse_cnt_reg, parse_cnt_next;
    logic [15:0] mem_cnt_reg, mem_cnt_next;
    logic [15:0] wr_cnt_reg, wr_cnt_next;
    logic [14:0] limit_reg;

    // Command fields of the word in force this byte
    logic [15:0] cmd_word;
    logic [15:0] given_addr;
    logic        explicit_addr;
    logic [2:0]  sp;
    logic [1:0]  sc;
    logic [6:0]  cnt;
    logic        inc, wr, ctl, bad_space;
    logic [15:0] lim;

    assign explicit_addr = (phase_reg == PH_ADDR_HI);
    assign cmd_word   = (phase_reg == PH_CMD_HI) ? {byte_data, cmd_reg[7:0]} : cmd_reg;
    assign given_addr = {byte_data, cur_addr_reg[7:0]};
    assign sp  = cmd_word[12:10];
    assign sc  = cmd_word[9:8];
    assign cnt = cmd_word[6:0];
    assign inc = cmd_word[CMD_INC_BIT];
    assign wr  = cmd_word[CMD_WRITE_BIT];
    assign ctl = cmd_word[CMD_CTRL_BIT];
    assign bad_space = (sp == 3'd1) || (sp == 3'd5);
    assign lim = space_limit(sp, limit_reg);

    // Command start checks
    logic [15:0] start_addr;
    logic [16:0] last_word;
    logic [1:0]  start_fail;

    assign start_addr = explicit_addr ? (given_addr >> sc) : next_addr_reg[sp];
    assign last_word  = inc ? ({1'b0, start_addr} + {10'd0, cnt} - 17'd1)
                            : {1'b0, start_addr};

    always_comb
    begin
        start_fail = ST_OK;
        if (ctl)
        begin
            if (sc != 2'd1)                         start_fail = ST_PARSE;
            else if (wr)                            start_fail = ST_WRITE;
            else if (bad_space)                     start_fail = ST_PARSE;
            else if (cnt >= 7'(CONTROL_WORDS))      start_fail = ST_MEM;
        end
        else if (bad_space || (sc != size_for_space(sp)))
            start_fail = ST_PARSE;
        else if (!wr && (last_word >= {1'b0, lim}))
            start_fail = ST_MEM;
        else if (wr && (start_addr >= lim))
            start_fail = ST_MEM;
    end

    // Write element assembly
    logic [2:0]  idx_inc;
    logic        elem_done;
    logic [31:0] shifted;
    logic [15:0] cur_addr_inc;
    logic [6:0]  elem_dec;

    assign idx_inc      = {1'b0, idx_reg} + 3'd1;
    assign elem_done    = ({1'b0, idx_inc} >= (4'd1 << sc));
    assign shifted      = shift_reg | ({24'd0, byte_data} << {idx_reg, 3'b000});
    assign cur_addr_inc = cur_addr_reg + {15'd0, inc};
    assign elem_dec     = elem_left_reg - 7'd1;

    // Per-byte next state and results
    logic [1:0]  case_fail, fail_total, pf_final;
    logic        acc_valid, na_we;
    logic [15:0] na_value;
    result_t     acc, pkt_end;

    always_comb
    begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        cur_addr_next  = cur_addr_reg;
        elem_left_next = elem_left_reg;
        shift_next     = shift_reg;
        idx_next       = idx_reg;
        case_fail      = ST_OK;
        acc_valid      = 1'b0;
        na_we          = 1'b0;
        na_value       = start_addr;
        acc            = '0;
        acc.space      = sp;
        acc.size_code  = sc;
        acc.increment  = inc;
        acc.error_bits    = sticky_reg;
        acc.parse_errors  = parse_cnt_reg;
        acc.memory_errors = mem_cnt_reg;
        acc.write_errors  = wr_cnt_reg;

        unique case (phase_reg) inside
            PH_CMD_LO:
            begin
                cmd_next   = {8'd0, byte_data};
                phase_next = PH_CMD_HI;
                if (byte_last) case_fail = ST_MEM;
            end
            PH_ADDR_LO:
            begin
                cur_addr_next = {8'd0, byte_data};
                phase_next    = PH_ADDR_HI;
                if (byte_last) case_fail = ST_PARSE;
            end
            PH_CMD_HI, PH_ADDR_HI:
            begin
                cmd_next = cmd_word;
                if (explicit_addr) cur_addr_next = given_addr;
                if (!explicit_addr && (cnt == 7'd0))
                    case_fail = ST_PARSE;
                else if (!explicit_addr && cmd_word[CMD_ADDR_BIT])
                begin
                    if (byte_last) case_fail = ST_PARSE;
                    else phase_next = PH_ADDR_LO;
                end
                else
                begin
                    phase_next = PH_CMD_LO;
                    if (!ctl) cur_addr_next = start_addr;
                    if (start_fail != ST_OK)
                        case_fail = start_fail;
                    else if (ctl)
                    begin
                        acc_valid        = 1'b1;
                        acc.kind         = KIND_CTRL;
                        acc.word_address = explicit_addr ? given_addr : 16'd0;
                        acc.burst_count  = cnt;
                    end
                    else if (!wr)
                    begin
                        acc_valid        = 1'b1;
                        acc.kind         = KIND_READ;
                        acc.word_address = start_addr;
                        acc.burst_count  = cnt;
                        na_we            = 1'b1;
                        na_value         = inc ? (start_addr + {9'd0, cnt}) : start_addr;
                    end
                    else
                    begin
                        elem_left_next = cnt;
                        shift_next     = '0;
                        idx_next       = '0;
                        phase_next     = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (!elem_done)
                begin
                    shift_next = shifted;
                    idx_next   = idx_inc[1:0];
                end
                else if (sp == SPACE_WRITE_ONLY_ERR)
                    case_fail = ST_WRITE;
                else
                begin
                    acc_valid        = 1'b1;
                    acc.kind         = KIND_WRITE;
                    acc.word_address = cur_addr_reg;
                    acc.burst_count  = 7'd1;
                    acc.write_data   = shifted;
                    cur_addr_next    = cur_addr_inc;
                    elem_left_next   = elem_dec;
                    shift_next       = '0;
                    idx_next         = '0;
                    if (elem_dec == 7'd0)
                    begin
                        na_we      = 1'b1;
                        na_value   = cur_addr_inc;
                        phase_next = PH_CMD_LO;
                    end
                    else if (cur_addr_inc >= lim)
                        case_fail = ST_MEM;
                end
            end
            PH_DROP:
            begin
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase

        // At most one failure per byte: a case failure or a truncated packet
        fail_total = case_fail;
        if ((case_fail == ST_OK) && byte_last && (phase_next != PH_CMD_LO)
            && (pf_reg == ST_OK))
            fail_total = ST_MEM;

        pf_next        = pf_reg;
        sticky_next    = sticky_reg;
        parse_cnt_next = parse_cnt_reg;
        mem_cnt_next   = mem_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        case (fail_total)
            ST_PARSE:
            begin
                sticky_next = sticky_reg | ERR_PARSE;
                if (parse_cnt_reg != COUNT_MAX) parse_cnt_next = parse_cnt_reg + 16'd1;
            end
            ST_MEM:
            begin
                sticky_next = sticky_reg | ERR_MEM;
                if (mem_cnt_reg != COUNT_MAX) mem_cnt_next = mem_cnt_reg + 16'd1;
            end
            ST_WRITE:
            begin
                sticky_next = sticky_reg | ERR_WRITE;
                if (wr_cnt_reg != COUNT_MAX) wr_cnt_next = wr_cnt_reg + 16'd1;
            end
            default:
            begin
            end
        endcase
        pf_final = (fail_total != ST_OK) ? fail_total : pf_reg;

        if (fail_total != ST_OK)
        begin
            pf_next    = fail_total;
            phase_next = PH_DROP;
        end
        if (byte_last)
        begin
            phase_next     = PH_CMD_LO;
            pf_next        = ST_OK;
            elem_left_next = '0;
            shift_next     = '0;
            idx_next       = '0;
        end

        pkt_end               = '0;
        pkt_end.kind          = KIND_END;
        pkt_end.status        = pf_final;
        pkt_end.error_bits    = sticky_next;
        pkt_end.parse_errors  = parse_cnt_next;
        pkt_end.memory_errors = mem_cnt_next;
        pkt_end.write_errors  = wr_cnt_next;
    end

    // Results in order: access first, packet end after it
    always_comb
    begin
        push.first_valid  = byte_take && (acc_valid || byte_last);
        push.second_valid = byte_take && acc_valid && byte_last;
        push.first        = acc_valid ? acc : pkt_end;
        push.second       = pkt_end;
    end

    // Register update on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD_LO;
            cmd_reg       <= '0;
            cur_addr_reg  <= '0;
            elem_left_reg <= '0;
            shift_reg     <= '0;
            idx_reg       <= '0;
            pf_reg        <= ST_OK;
            sticky_reg    <= '0;
            parse_cnt_reg <= '0;
            mem_cnt_reg   <= '0;
            wr_cnt_reg    <= '0;
            for (int i = 0; i < SPACES; i++) next_addr_reg[i] <= '0;
        end
        else if (byte_take)
        begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            cur_addr_reg  <= cur_addr_next;
            elem_left_reg <= elem_left_next;
            shift_reg     <= shift_next;
            idx_reg       <= idx_next;
            pf_reg        <= pf_next;
            sticky_reg    <= sticky_next;
            parse_cnt_reg <= parse_cnt_next;
            mem_cnt_reg   <= mem_cnt_next;
            wr_cnt_reg    <= wr_cnt_next;
            if (na_we) next_addr_reg[sp] <= na_value;
        end
    end

    // Space 0 limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= SPACE0_LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

endmodule

`default_nettype wire

/* design/lbp_res_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one.
// Uses lbp_pkg for the result type.
`default_nettype none

module lbp_res_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lbp_pkg::res_push_t push,
    output logic                    room_for_two,
    output logic                    out_valid,
    input  wire logic               out_take,
    output lbp_pkg::result_t        out_data
);
    import lbp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t        store_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  wr_ptr_plus;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == PW'(DEPTH - 1)) q = '0;
        else q = p + PW'(1);
        return q;
    endfunction

    assign wr_ptr_plus  = ptr_inc(wr_ptr_reg);
    assign room_for_two = (count_reg <= CW'(DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign out_data     = store_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push.second_valid) wr_ptr_next = ptr_inc(wr_ptr_plus);
        else if (push.first_valid) wr_ptr_next = wr_ptr_plus;
        rd_ptr_next = out_take ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.first_valid) + CW'(push.second_valid)
                      - CW'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.first_valid) store_reg[wr_ptr_reg] <= push.first;
        if (push.second_valid) store_reg[wr_ptr_plus] <= push.second;
    end

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for lbp16_command_stream_parser_unit: drives directed and random
// LBP16 packets and compares every result, in order, with an in-bench command predictor.
// Depends on lbp_pkg and the lbp_cfg_if, lbp_byte_if and lbp_res_if interfaces.

module tb;
    import lbp_pkg::*;

    // Command decoder predictor plus the queue of results it still owes
    class command_tracker;
        phase_t      ph;
        logic [15:0] cmd;
        logic [15:0] cur_addr;
        logic [6:0]  elems_left;
        logic [31:0] data_acc;
        int unsigned byte_idx;
        logic [15:0] next_addr [SPACES];
        logic [1:0]  pkt_status;
        logic [2:0]  sticky;
        logic [15:0] n_parse;
        logic [15:0] n_mem;
        logic [15:0] n_write;
        logic [14:0] zero_limit;
        result_t     pending_results [$];
        int          mismatches;

        function new();
            ph         = PH_CMD_LO;
            cmd        = '0;
            cur_addr   = '0;
            elems_left = '0;
            data_acc   = '0;
            byte_idx   = 0;
            foreach (next_addr[i]) next_addr[i] = '0;
            pkt_status = ST_OK;
            sticky     = '0;
            n_parse    = '0;
            n_mem      = '0;
            n_write    = '0;
            zero_limit = SPACE0_LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 60) $display("%0t ns: mismatch: %s", $time, what);
        endfunction

        // Word limit of each space
        function logic [15:0] limit_of(logic [2:0] sp);
            case (sp) inside
                3'd0:    return {1'b0, zero_limit};
                3'd2:    return 16'd32;
                3'd3:    return 16'd4;
                3'd4, 3'd6, 3'd7: return 16'd16;
                default: return 16'd0;
            endcase
        endfunction

        function void fail(logic [1:0] code);
            pkt_status = code;
            case (code)
                ST_PARSE:
                begin
                    sticky |= ERR_PARSE;
                    if (n_parse != COUNT_MAX) n_parse++;
                end
                ST_MEM:
                begin
                    sticky |= ERR_MEM;
                    if (n_mem != COUNT_MAX) n_mem++;
                end
                default:
                begin
                    sticky |= ERR_WRITE;
                    if (n_write != COUNT_MAX) n_write++;
                end
            endcase
            ph = PH_DROP;
        endfunction

        function void push(logic [1:0] kind, logic [2:0] sp, logic [15:0] addr,
                           logic [1:0] sc, logic [6:0] cnt, logic inc,
                           logic [31:0] data, logic [1:0] st);
            result_t r;
            r.kind          = kind;
            r.space         = sp;
            r.word_address  = addr;
            r.size_code     = sc;
            r.burst_count   = cnt;
            r.increment     = inc;
            r.write_data    = data;
            r.status        = st;
            r.error_bits    = sticky;
            r.parse_errors  = n_parse;
            r.memory_errors = n_mem;
            r.write_errors  = n_write;
            pending_results.push_back(r);
        endfunction

        // Write element address must sit below the space limit
        function void check_elem();
            if (cur_addr >= limit_of(cmd[12:10])) fail(ST_MEM);
        endfunction

        function void start_cmd(bit explicit);
            logic [2:0]  sp;
            logic [1:0]  sc;
            logic [6:0]  cnt;
            logic        inc;
            logic        wr;
            logic [31:0] last_word;
            sp  = cmd[12:10];
            sc  = cmd[9:8];
            cnt = cmd[6:0];
            inc = cmd[CMD_INC_BIT];
            wr  = cmd[CMD_WRITE_BIT];
            ph  = PH_CMD_LO;
            // control reads: own rule set, next addresses untouched
            if (cmd[CMD_CTRL_BIT]) begin
                if (sc != 2'd1) fail(ST_PARSE);
                else if (wr) fail(ST_WRITE);
                else if (sp == 3'd1 || sp == 3'd5) fail(ST_PARSE);
                else if (cnt >= CONTROL_WORDS) fail(ST_MEM);
                else push(KIND_CTRL, sp, explicit ? cur_addr : 16'd0, 2'd1, cnt, inc,
                          32'd0, ST_OK);
                return;
            end
            if (sp == 3'd1 || sp == 3'd5 ||
                sc != ((sp == 3'd0 || sp == 3'd3) ? 2'd2 : 2'd1)) begin
                fail(ST_PARSE);
                return;
            end
            cur_addr = explicit ? (cur_addr >> sc) : next_addr[sp];
            if (!wr) begin
                // last word computed without wrap
                last_word = inc ? {16'd0, cur_addr} + {25'd0, cnt} - 32'd1 : {16'd0, cur_addr};
                if (last_word >= {16'd0, limit_of(sp)}) begin
                    fail(ST_MEM);
                    return;
                end
                push(KIND_READ, sp, cur_addr, sc, cnt, inc, 32'd0, ST_OK);
                next_addr[sp] = inc ? cur_addr + 16'(cnt) : cur_addr;
                return;
            end
            elems_left = cnt;
            data_acc   = '0;
            byte_idx   = 0;
            ph         = PH_DATA;
            check_elem();
        endfunction

        function void finish_elem();
            logic [2:0] sp;
            logic       inc;
            sp  = cmd[12:10];
            inc = cmd[CMD_INC_BIT];
            if (sp == SPACE_WRITE_ONLY_ERR) begin
                fail(ST_WRITE);
                return;
            end
            push(KIND_WRITE, sp, cur_addr, cmd[9:8], 7'd1, inc, data_acc, ST_OK);
            if (inc) cur_addr = cur_addr + 16'd1;
            elems_left = elems_left - 7'd1;
            data_acc   = '0;
            byte_idx   = 0;
            if (elems_left == 7'd0) begin
                next_addr[sp] = cur_addr;
                ph = PH_CMD_LO;
            end else begin
                check_elem();
            end
        endfunction

        // One accepted packet byte
        function void note_byte(logic [7:0] b, logic is_last);
            case (ph)
                PH_CMD_LO:
                begin
                    cmd = {8'd0, b};
                    ph  = PH_CMD_HI;
                    if (is_last) fail(ST_MEM);
                end
                PH_CMD_HI:
                begin
                    cmd[15:8] = b;
                    if (cmd[6:0] == 7'd0) fail(ST_PARSE);
                    else if (cmd[CMD_ADDR_BIT]) begin
                        if (is_last) fail(ST_PARSE);
                        else ph = PH_ADDR_LO;
                    end else start_cmd(1'b0);
                end
                PH_ADDR_LO:
                begin
                    cur_addr = {8'd0, b};
                    ph = PH_ADDR_HI;
                    if (is_last) fail(ST_PARSE);
                end
                PH_ADDR_HI:
                begin
                    cur_addr[15:8] = b;
                    start_cmd(1'b1);
                end
                PH_DATA:
                begin
                    data_acc = data_acc | ({24'd0, b} << (8 * (byte_idx % 4)));
                    byte_idx++;
                    if (byte_idx >= (1 << cmd[9:8])) finish_elem();
                end
                default: ;
            endcase
            // packet end: cut-off work is a memory error, then status
            if (is_last) begin
                if (ph != PH_CMD_LO && pkt_status == ST_OK) fail(ST_MEM);
                push(KIND_END, 3'd0, 16'd0, 2'd0, 7'd0, 1'b0, 32'd0, pkt_status);
                ph         = PH_CMD_LO;
                pkt_status = ST_OK;
                elems_left = '0;
                data_acc   = '0;
                byte_idx   = 0;
            end
        endfunction

        function void cmp(string name, logic [31:0] got, logic [31:0] want, logic [1:0] kind);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h (kind %0d)", name, got, want, kind));
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending_results.size() == 0) begin
                report($sformatf("result kind %0d with none expected", got.kind));
                return;
            end
            e = pending_results.pop_front();
            cmp("kind", 32'(got.kind), 32'(e.kind), e.kind);
            cmp("space", 32'(got.space), 32'(e.space), e.kind);
            cmp("word_address", 32'(got.word_address), 32'(e.word_address), e.kind);
            cmp("size_code", 32'(got.size_code), 32'(e.size_code), e.kind);
            cmp("burst_count", 32'(got.burst_count), 32'(e.burst_count), e.kind);
            cmp("increment", 32'(got.increment), 32'(e.increment), e.kind);
            cmp("write_data", got.write_data, e.write_data, e.kind);
            cmp("status", 32'(got.status), 32'(e.status), e.kind);
            cmp("error_bits", 32'(got.error_bits), 32'(e.error_bits), e.kind);
            cmp("parse_errors", 32'(got.parse_errors), 32'(e.parse_errors), e.kind);
            cmp("memory_errors", 32'(got.memory_errors), 32'(e.memory_errors), e.kind);
            cmp("write_errors", 32'(got.write_errors), 32'(e.write_errors), e.kind);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lbp_cfg_if  limit_cfg ();
    lbp_byte_if pkt_bytes ();
    lbp_res_if  results ();

    command_tracker tracker;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             bytes_sent;
    logic [14:0]    limit_now;
    logic [7:0]     pkt_q [$];

    lbp16_command_stream_parser_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit_cfg (limit_cfg),
        .pkt_bytes (pkt_bytes),
        .results   (results)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result sink with random stalls
    initial
    begin
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            results.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Transaction monitor: config writes, accepted bytes, accepted results
    always @(posedge clk)
    begin : watch
        result_t got;
        if (rst_n) begin
            if (limit_cfg.valid && limit_cfg.ready) tracker.zero_limit = limit_cfg.data;
            if (pkt_bytes.valid && pkt_bytes.ready)
                tracker.note_byte(pkt_bytes.byte_in, pkt_bytes.last_byte);
            if (results.valid && results.ready) begin
                got.kind          = results.kind;
                got.space         = results.space;
                got.word_address  = results.word_address;
                got.size_code     = results.size_code;
                got.burst_count   = results.burst_count;
                got.increment     = results.increment;
                got.write_data    = results.write_data;
                got.status        = results.status;
                got.error_bits    = results.error_bits;
                got.parse_errors  = results.parse_errors;
                got.memory_errors = results.memory_errors;
                got.write_errors  = results.write_errors;
                tracker.check_result(got);
            end
        end
    end

    function automatic logic [15:0] cmd_word(bit wr, bit has_addr, bit ctrl, logic [2:0] sp,
                                             logic [1:0] sc, bit inc, logic [6:0] cnt);
        return {wr, has_addr, ctrl, sp, sc, inc, cnt};
    endfunction

    // Hold the byte channel until every owed result is out
    task automatic drain_wait();
        pkt_bytes.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt_bytes.valid <= 1'b0;
            @(posedge clk);
        end
        if ($urandom_range(999) == 0) drain_wait();
        pkt_bytes.valid     <= 1'b1;
        pkt_bytes.byte_in   <= b;
        pkt_bytes.last_byte <= is_last;
        @(posedge clk);
        while (!pkt_bytes.ready) @(posedge clk);
    endtask

    task automatic send_word(input logic [15:0] w, input logic is_last);
        send_byte(w[7:0], 1'b0);
        send_byte(w[15:8], is_last);
    endtask

    task automatic write_limit(input logic [14:0] v);
        drain_wait();
        repeat (8) @(posedge clk);
        limit_cfg.valid <= 1'b1;
        limit_cfg.data  <= v;
        @(posedge clk);
        while (!limit_cfg.ready) @(posedge clk);
        limit_cfg.valid <= 1'b0;
        limit_now = v;
    endtask

    // Append one command (mostly well formed) to the packet under construction
    function automatic void add_command();
        int          sel;
        int          cnt;
        int          lim;
        int          span;
        logic [2:0]  sp;
        logic [1:0]  sc;
        bit          inc;
        bit          has_addr;
        logic [15:0] word;
        logic [15:0] cw;
        sel      = $urandom_range(99);
        inc      = 1'($urandom_range(1));
        has_addr = ($urandom_range(99) < 60);
        if (sel < 12) begin
            // noise: any command word, then stray bytes
            cw = 16'($urandom);
            pkt_q.push_back(cw[7:0]);
            pkt_q.push_back(cw[15:8]);
            repeat ($urandom_range(4)) pkt_q.push_back(8'($urandom));
            return;
        end
        case ($urandom_range(5))
            0:       sp = 3'd0;
            1:       sp = 3'd2;
            2:       sp = 3'd3;
            3:       sp = 3'd4;
            4:       sp = 3'd6;
            default: sp = 3'd7;
        endcase
        sc = (sp == 3'd0 || sp == 3'd3) ? 2'd2 : 2'd1;
        case (sp)
            3'd0:    lim = int'(limit_now);
            3'd2:    lim = 32;
            3'd3:    lim = 4;
            default: lim = 16;
        endcase
        if (sel < 27) begin
            // control read, sometimes with an oversized count
            cnt  = ($urandom_range(9) == 0) ? $urandom_range(8, 127) : $urandom_range(1, 7);
            cw   = cmd_word(1'b0, has_addr, 1'b1, sp, 2'd1, inc, 7'(cnt));
            word = 16'($urandom);
        end else begin
            // reads below 60, writes above; addresses mostly in range
            cnt = (sel < 60) ? $urandom_range(1, (lim > 16) ? 16 : lim) : $urandom_range(1, 4);
            if (sel < 60 && $urandom_range(9) == 0) cnt = $urandom_range(1, 127);
            span = (inc && cnt <= lim) ? lim - cnt : lim - 1;
            word = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
            if (has_addr) word = word << sc;
            cw = cmd_word(sel >= 60, has_addr, 1'b0, sp, sc, inc, 7'(cnt));
        end
        pkt_q.push_back(cw[7:0]);
        pkt_q.push_back(cw[15:8]);
        if (has_addr) begin
            pkt_q.push_back(word[7:0]);
            pkt_q.push_back(word[15:8]);
        end
        if (cw[CMD_WRITE_BIT] && !cw[CMD_CTRL_BIT])
            repeat (cnt << sc) pkt_q.push_back(8'($urandom));
    endfunction

    // Build and send one packet, now and then cut short
    task automatic send_packet(input int ncmds);
        int keep;
        pkt_q.delete();
        repeat (ncmds) add_command();
        keep = pkt_q.size();
        if ($urandom_range(99) < 8) keep = $urandom_range(1, pkt_q.size());
        for (int i = 0; i < keep; i++) send_byte(pkt_q[i], i == keep - 1);
        bytes_sent += keep;
    endtask

    // Main sequence
    initial
    begin
        int          phase_start;
        int          wait_cycles;
        logic [14:0] next_limit;
        tracker = new();
        rst_n               <= 1'b0;
        pkt_bytes.valid     <= 1'b0;
        pkt_bytes.byte_in   <= 8'd0;
        pkt_bytes.last_byte <= 1'b0;
        limit_cfg.valid     <= 1'b0;
        limit_cfg.data      <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        limit_now      = SPACE0_LIMIT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one case per rule
        send_byte(8'hff, 1'b1);                                         // lone command byte
        send_word(16'h0000, 1'b1);                                      // zero count
        send_word(cmd_word(1'b0, 1'b1, 1'b1, 3'd7, 2'd1, 1'b1, 7'd7), 1'b0);
        drain_wait();                                                   // pause mid-packet
        send_word(16'hffff, 1'b1);                                      // control read, address
        send_word(cmd_word(1'b0, 1'b0, 1'b1, 3'd0, 2'd2, 1'b0, 7'd3), 1'b1); // control size
        send_word(cmd_word(1'b1, 1'b0, 1'b1, 3'd0, 2'd1, 1'b0, 7'd3), 1'b1); // control write
        send_word(cmd_word(1'b0, 1'b0, 1'b1, 3'd5, 2'd1, 1'b0, 7'd1), 1'b1); // control space
        send_word(cmd_word(1'b0, 1'b0, 1'b1, 3'd2, 2'd1, 1'b1, 7'd127), 1'b1); // control count
        send_word(cmd_word(1'b0, 1'b1, 1'b0, 3'd0, 2'd2, 1'b1, 7'd1), 1'b0);
        send_word(16'hfffc, 1'b1);                                      // top word of space 0
        send_word(cmd_word(1'b0, 1'b1, 1'b0, 3'd2, 2'd1, 1'b0, 7'd1), 1'b0);
        send_byte(8'h00, 1'b1);                                         // address cut off
        send_word(cmd_word(1'b1, 1'b0, 1'b0, 3'd7, 2'd1, 1'b0, 7'd1), 1'b0);
        send_word(16'h5aa5, 1'b1);                                      // write to space 7
        send_word(cmd_word(1'b1, 1'b0, 1'b0, 3'd2, 2'd1, 1'b1, 7'd1), 1'b0);
        send_byte(8'h80, 1'b1);                                         // end inside data

        // Random phases, each with its own limit and idle pattern
        for (int ph_i = 0; ph_i < 8; ph_i++)
        begin
            case (ph_i) inside
                0, 3, 7: next_limit = 15'd16384;
                1, 5:    next_limit = 15'd1;
                4:       next_limit = 15'($urandom_range(1, 64));
                default: next_limit = 15'($urandom_range(1, 16384));
            endcase
            write_limit(next_limit);
            case (ph_i % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 165) send_packet($urandom_range(1, 4));
        end

        // Drain and finish
        pkt_bytes.valid <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while (tracker.pending_results.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (tracker.pending_results.size() != 0)
            tracker.report($sformatf("%0d results never arrived",
                                     tracker.pending_results.size()));
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* lbp16_command_stream_parser_unit.f */
design/lbp_pkg.sv
design/lbp_byte_if.sv
design/lbp_res_if.sv
design/lbp_cfg_if.sv
design/lbp_parse_core.sv
design/lbp_res_fifo.sv
design/lbp16_command_stream_parser_unit.sv
test/tb.sv
